>>> design/ptpd_pkg.sv
// Package for the homogeneous point transform with perspective divide.
// Holds the transaction types, register reset values and pipeline sizes.
// No dependencies.
package ptpd_pkg;

  localparam int NUM_REGS   = 8;
  localparam int REG_W      = 64;
  localparam int IDX_W      = $clog2(NUM_REGS);
  localparam int DIV_STEPS  = 32;

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
  } point_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic               w_zero;
    logic               saturated;
  } result_t;

endpackage

>>> design/point_transform_perspective_divide_unit.sv
// Top level: 4x4 homogeneous transform of a Q16.16 point and divide by w.
// Depends on ptpd_pkg for types, register resets and pipeline sizes.
//
//   channel | signals                        | transaction
//   pt      | pt_valid, pt_ready, pt_data    | one point in
//   res     | res_valid, res_ready, res_data | one transformed point out
//   cfg     | cfg_we, cfg_index, cfg_data    | one matrix register write
//
// One transaction is accepted per cycle while pt_ready is high; a point
// then runs through 32 restoring divider steps per lane to give its result.
// Reset clears all valid bits and loads the identity matrix.
// A stalled output fills a one-entry skid register, and only then does
// pt_ready fall, so the whole pipeline holds without losing anything.
module point_transform_perspective_divide_unit import ptpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pt_valid,
  output logic                 pt_ready,
  input  point_t               pt_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output result_t              res_data,
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  typedef struct packed {
    logic [2:0][63:0] rem;
    logic [2:0][31:0] low;
    logic [2:0][31:0] q;
    logic [2:0]       nneg;
    logic [2:0]       ovf;
    logic [63:0]      wmag;
    logic             wneg;
    logic             wzero;
  } div_t;

  logic [REG_W-1:0] cfg_regs [NUM_REGS];
  logic signed [31:0] m [4][4];

  logic en;
  logic v_in, v_mul, v_sum, v_sm;
  point_t pt;
  logic signed [63:0] prod [4][4];
  logic signed [65:0] sums [4];
  logic [3:0] sneg;
  logic [3:0][63:0] smag;
  logic [DIV_STEPS:0] dv_v;
  div_t dv [DIV_STEPS+1];
  div_t dv_init;
  result_t fin;
  logic skid_valid;
  result_t skid_data;
  logic leaving;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_regs[i] <= REG_RESET[i];
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = cfg_regs[r*2 + c/2][32*(c%2) +: 32];
      end
    end
  end

  assign en = !skid_valid;
  assign pt_ready = en;
  assign leaving = dv_v[DIV_STEPS] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in  <= 1'b0;
      v_mul <= 1'b0;
      v_sum <= 1'b0;
      v_sm  <= 1'b0;
      dv_v  <= '0;
    end else if (en) begin
      v_in  <= pt_valid;
      v_mul <= v_in;
      v_sum <= v_mul;
      v_sm  <= v_sum;
      dv_v  <= {dv_v[DIV_STEPS-1:0], v_sm};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt <= pt_data;
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= 64'(pt.x_in) * 64'(m[r][0]);
        prod[r][1] <= 64'(pt.y_in) * 64'(m[r][1]);
        prod[r][2] <= 64'(pt.z_in) * 64'(m[r][2]);
        prod[r][3] <= {{16{m[r][3][31]}}, m[r][3], 16'h0};
        sums[r] <= 66'(prod[r][0]) + 66'(prod[r][1]) + 66'(prod[r][2])
                 + 66'(prod[r][3]);
        sneg[r] <= sums[r][65];
        smag[r] <= sums[r][65] ? 64'(-sums[r]) : sums[r][63:0];
      end
      dv[0] <= dv_init;
    end
  end

  always_comb begin
    dv_init = '0;
    dv_init.wmag  = smag[3];
    dv_init.wneg  = sneg[3];
    dv_init.wzero = (smag[3] == 64'h0);
    for (int l = 0; l < 3; l++) begin
      dv_init.nneg[l] = sneg[l];
      dv_init.ovf[l]  = {16'h0, smag[l]} >= {smag[3], 16'h0};
      dv_init.rem[l]  = {16'h0, smag[l][63:16]};
      dv_init.low[l]  = {smag[l][15:0], 16'h0};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    div_t nxt;
    always_comb begin : step
      logic [64:0] t;
      logic qb;
      nxt = dv[k];
      for (int l = 0; l < 3; l++) begin
        t  = {dv[k].rem[l], dv[k].low[l][31]};
        qb = 1'b0;
        if (t >= {1'b0, dv[k].wmag}) begin
          t  = t - {1'b0, dv[k].wmag};
          qb = 1'b1;
        end
        nxt.rem[l] = t[63:0];
        nxt.low[l] = {dv[k].low[l][30:0], 1'b0};
        nxt.q[l]   = {dv[k].q[l][30:0], qb};
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv[k+1] <= nxt;
    end
  end

  always_comb begin : finish
    logic [2:0][31:0] val;
    logic [2:0] sat;
    logic neg;
    div_t d;
    d = dv[DIV_STEPS];
    for (int l = 0; l < 3; l++) begin
      neg = (d.nneg[l] != d.wneg) && (d.q[l] != 32'h0 || d.ovf[l]);
      sat[l] = 1'b0;
      if (d.ovf[l]) begin
        sat[l] = 1'b1;
        val[l] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (neg) begin
        if (d.q[l] > 32'h8000_0000) begin
          sat[l] = 1'b1;
          val[l] = 32'h8000_0000;
        end else begin
          val[l] = -d.q[l];
        end
      end else if (d.q[l] > 32'h7FFF_FFFF) begin
        sat[l] = 1'b1;
        val[l] = 32'h7FFF_FFFF;
      end else begin
        val[l] = d.q[l];
      end
    end
    if (d.wzero) begin
      fin = '0;
      fin.w_zero = 1'b1;
    end else begin
      fin.x_out = val[0];
      fin.y_out = val[1];
      fin.z_out = val[2];
      fin.w_zero = 1'b0;
      fin.saturated = |sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= leaving;
      end
    end else if (leaving) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || res_ready) begin
      res_data <= skid_valid ? skid_data : fin;
    end else if (leaving) begin
      skid_data <= fin;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid) else $error("skid holds data with no output");

  a_wzero_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.w_zero |-> res_data.x_out == 0 && res_data.y_out == 0
      && res_data.z_out == 0 && !res_data.saturated)
    else $error("zero w result not cleared");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(dv_v) || $past(res_ready))
    else $error("pipeline moved while skid full");

endmodule
